/* src/mcss_pkg.sv */
// ----------------------------------------------------------------------------
// mcss_pkg
// shared widths, register indexes and status types of the sample scheduler
// ----------------------------------------------------------------------------
package mcss_pkg;

    localparam int DATA_W           = 32;
    localparam int CHAN_W           = 2;
    localparam int CFG_IDX_W        = 3;
    localparam int ACTIVE_W         = 3;
    localparam int NUM_CHANNELS_DEF = 4;
    localparam int MAX_TRIGGERS     = 4;
    localparam int DIV_CNT_W        = $clog2(DATA_W);

    localparam logic [DATA_W-1:0]    PERIOD_RESET = DATA_W'(1000);
    localparam logic [ACTIVE_W-1:0]  ACTIVE_RESET = ACTIVE_W'(4);

    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD0 = CFG_IDX_W'(1);

    typedef struct packed {
        logic busy;
        logic done;
    } mcss_div_status_t;

endpackage

/* src/mcss_rem_unit.sv */
// ----------------------------------------------------------------------------
// mcss_rem_unit
// bit-serial restoring remainder unit, one quotient bit per cycle
// ----------------------------------------------------------------------------
module mcss_rem_unit (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [mcss_pkg::DATA_W-1:0]  dividend,
    input  logic [mcss_pkg::DATA_W-1:0]  divisor,
    output mcss_pkg::mcss_div_status_t   status,
    output logic [mcss_pkg::DATA_W-1:0]  remainder
);
    import mcss_pkg::*;

    localparam logic [DIV_CNT_W-1:0] CNT_LAST = DIV_CNT_W'(DATA_W - 1);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DATA_W-1:0]    dvd_reg, dvd_next;
    logic [DATA_W-1:0]    dsr_reg, dsr_next;
    logic [DATA_W-1:0]    rem_reg, rem_next;
    logic [DATA_W:0]      shifted;
    logic [DATA_W:0]      trial;

    assign shifted = {rem_reg, dvd_reg[DATA_W-1]};
    assign trial   = shifted - {1'b0, dsr_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        dsr_next  = dsr_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            dvd_next  = dividend;
            dsr_next  = divisor;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            dvd_next = {dvd_reg[DATA_W-2:0], 1'b0};
            rem_next = trial[DATA_W] ? shifted[DATA_W-1:0] : trial[DATA_W-1:0];
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_LAST)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        dsr_reg <= dsr_next;
        rem_reg <= rem_next;
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign remainder   = rem_reg;

`ifndef SYNTHESIS
    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg)
        else $error("remainder done while still busy");
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(done_reg) |-> $past(busy_reg))
        else $error("remainder done without a running division");
    a_start_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy_reg)
        else $error("division started while busy");
`endif

endmodule

/* src/multi_channel_sample_scheduler.sv */
// flow: an input transfer starts a scan of S channels, S the active count capped at SCAN_MAX;
// a due channel whose due time moves goes through emit, compare, remainder, fix-up, write
// and pick, one whose due time does not through emit, compare and pick; the input stalls
// until the pass ends back in idle; one pass at a time, and output stalls hold the emit step;
// the shared subtractor and remainder unit serialise these steps
// reset: asynchronous active low; periods 1000, four active channels, next due 0
// ----------------------------------------------------------------------------
// multi_channel_sample_scheduler
// walks the active channels per pass, emits a trigger for each due channel
// and moves its next due time forward by whole periods
// ----------------------------------------------------------------------------
module multi_channel_sample_scheduler #(
    parameter int NUM_CHANNELS = mcss_pkg::NUM_CHANNELS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [mcss_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mcss_pkg::DATA_W-1:0]     cfg_data,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [mcss_pkg::DATA_W-1:0]     now,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [mcss_pkg::CHAN_W-1:0]     channel,
    output logic [mcss_pkg::DATA_W-1:0]     sample_time,
    output logic                            last
);
    import mcss_pkg::*;

    localparam int SCAN_MAX = (NUM_CHANNELS < MAX_TRIGGERS) ? NUM_CHANNELS : MAX_TRIGGERS;
    localparam int IDX_W    = (SCAN_MAX > 1) ? $clog2(SCAN_MAX) : 1;
    localparam int CNT_W    = $clog2(SCAN_MAX + 1);

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_SCAN  = 8'b0000_0010,
        ST_PICK  = 8'b0000_0100,
        ST_EMIT  = 8'b0000_1000,
        ST_CMP   = 8'b0001_0000,
        ST_DIV   = 8'b0010_0000,
        ST_FIX   = 8'b0100_0000,
        ST_WRITE = 8'b1000_0000
    } state_t;

    state_t               state_reg, state_next;
    logic [ACTIVE_W-1:0]  active_reg;
    logic [DATA_W-1:0]    period_reg [SCAN_MAX];
    logic [DATA_W-1:0]    next_due_reg [SCAN_MAX];
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [CNT_W-1:0]     scan_reg, scan_next;
    logic [SCAN_MAX-1:0]  due_reg, due_next;
    logic [DATA_W-1:0]    now_reg;
    logic [DATA_W-1:0]    target_reg;
    logic [DATA_W-1:0]    tmp_reg;
    logic                 rem_zero_reg;
    logic                 out_valid_reg, out_valid_next;
    logic [CHAN_W-1:0]    channel_reg;
    logic [DATA_W-1:0]    sample_time_reg;
    logic                 last_reg;

    logic [IDX_W-1:0]     idx;
    logic [DATA_W-1:0]    per_cur;
    logic [DATA_W-1:0]    nd_cur;
    logic [DATA_W-1:0]    sub_a, sub_b, sub_res;
    logic [CNT_W-1:0]     scan_in;
    logic [SCAN_MAX-1:0]  pick_onehot;
    logic [CNT_W-1:0]     pick_idx;
    logic                 slot_free;
    logic                 in_xfer;
    logic                 emit_load;
    logic                 div_start;
    logic                 nd_we;
    logic [CFG_IDX_W-1:0] cfg_off;
    mcss_div_status_t     div_stat;
    logic [DATA_W-1:0]    rem_val;

    assign idx     = cnt_reg[IDX_W-1:0];
    assign per_cur = period_reg[idx];
    assign nd_cur  = next_due_reg[idx];

    // shared subtractor
    always_comb
    begin
        case (state_reg)
            ST_SCAN:
            begin
                sub_a = now_reg;
                sub_b = nd_cur;
            end
            ST_EMIT:
            begin
                sub_a = now_reg;
                sub_b = per_cur;
            end
            ST_CMP:
            begin
                sub_a = target_reg;
                sub_b = nd_cur;
            end
            ST_FIX:
            begin
                sub_a = rem_val;
                sub_b = per_cur;
            end
            ST_WRITE:
            begin
                sub_a = target_reg;
                sub_b = tmp_reg;
            end
            default:
            begin
                sub_a = now_reg;
                sub_b = now_reg;
            end
        endcase
    end
    assign sub_res = sub_a - sub_b;

    assign scan_in = (active_reg > ACTIVE_W'(SCAN_MAX)) ? CNT_W'(SCAN_MAX)
                                                         : active_reg[CNT_W-1:0];

    // lowest pending due channel
    always_comb
    begin
        pick_onehot = '0;
        pick_idx    = '0;
        for (int i = SCAN_MAX - 1; i >= 0; i--)
        begin
            if (due_reg[i])
            begin
                pick_onehot = '0;
                pick_onehot[i] = 1'b1;
                pick_idx = CNT_W'(i);
            end
        end
    end

    assign slot_free = !out_valid_reg || !out_stall;
    assign in_xfer   = in_valid && !in_stall;
    assign emit_load = (state_reg == ST_EMIT) && slot_free;
    assign div_start = (state_reg == ST_CMP) && (per_cur != '0) && (nd_cur < target_reg);
    assign nd_we     = (state_reg == ST_WRITE);

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        scan_next      = scan_reg;
        due_next       = due_reg;
        out_valid_next = out_valid_reg && out_stall;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    cnt_next   = '0;
                    scan_next  = scan_in;
                    due_next   = '0;
                    state_next = (scan_in == '0) ? ST_IDLE : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                due_next[idx] = (sub_res >= per_cur);
                cnt_next      = cnt_reg + 1'b1;
                if (cnt_next == scan_reg)
                begin
                    state_next = ST_PICK;
                end
            end
            ST_PICK:
            begin
                if (due_reg == '0)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    cnt_next   = pick_idx;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    due_next       = due_reg & ~pick_onehot;
                    state_next     = ST_CMP;
                end
            end
            ST_CMP:
            begin
                state_next = div_start ? ST_DIV : ST_PICK;
            end
            ST_DIV:
            begin
                if (div_stat.done)
                begin
                    state_next = ST_FIX;
                end
            end
            ST_FIX:
            begin
                state_next = ST_WRITE;
            end
            ST_WRITE:
            begin
                state_next = ST_PICK;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            scan_reg      <= '0;
            due_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            scan_reg      <= scan_next;
            due_reg       <= due_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // configuration and per-channel state
    assign cfg_ready = 1'b1;
    assign cfg_off   = cfg_index - REG_PERIOD0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= ACTIVE_RESET;
            for (int i = 0; i < SCAN_MAX; i++)
            begin
                period_reg[i]   <= PERIOD_RESET;
                next_due_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_ACTIVE)
                begin
                    active_reg <= cfg_data[ACTIVE_W-1:0];
                end
                else if (cfg_index >= REG_PERIOD0 && cfg_off < CFG_IDX_W'(SCAN_MAX))
                begin
                    period_reg[cfg_off[IDX_W-1:0]] <= cfg_data;
                end
            end
            if (nd_we)
            begin
                next_due_reg[idx] <= rem_zero_reg ? target_reg : sub_res;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            now_reg <= now;
        end
        if (emit_load)
        begin
            target_reg      <= sub_res;
            channel_reg     <= CHAN_W'(idx);
            sample_time_reg <= now_reg;
            last_reg        <= ((due_reg & ~pick_onehot) == '0);
        end
        if (state_reg == ST_FIX)
        begin
            tmp_reg      <= sub_res;
            rem_zero_reg <= (rem_val == '0);
        end
    end

    mcss_rem_unit u_rem (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (sub_res),
        .divisor   (per_cur),
        .status    (div_stat),
        .remainder (rem_val)
    );

    assign in_stall    = (state_reg != ST_IDLE);
    assign out_valid   = out_valid_reg;
    assign channel     = channel_reg;
    assign sample_time = sample_time_reg;
    assign last        = last_reg;

`ifndef SYNTHESIS
    a_idle_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> (due_reg == '0))
        else $error("due channels left over in idle");
    a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> (state_reg == ST_DIV))
        else $error("remainder finished outside the divide step");
    a_div_busy_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (div_stat.busy || div_stat.done))
        else $error("waiting on an idle remainder unit");
    a_pick_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PICK) |-> ((due_reg >> scan_reg) == '0))
        else $error("due flag beyond the scanned channels");
`endif

endmodule
